@@ hdl/y86_instruction_executor_unit_assert.svh @@
// assertion macros for the y86 executor
// no dependencies
`ifndef Y86_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define Y86_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define Y86_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define Y86_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define Y86_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define Y86_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ hdl/y86_pkg.sv @@
// types and constants for the y86 executor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package y86_pkg;
    localparam int MEM_BYTES_DEF = 4096;
    localparam int NUM_REGS_DEF = 8;

    typedef struct packed {
        logic [1:0]         action;
        logic [11:0]        address;
        logic [7:0]         write_byte;
        logic signed [31:0] console_value;
        logic               console_eof;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [11:0]        program_counter;
        logic [7:0]         read_byte;
        logic [1:0]         print_kind;
        logic signed [31:0] print_value;
        logic               console_taken;
    } t_out;

    localparam logic [1:0] ACT_WR = 2'd0;
    localparam logic [1:0] ACT_RD = 2'd1;
    localparam logic [1:0] ACT_EX = 2'd2;

    localparam logic [1:0] ST_AOK = 2'd0;
    localparam logic [1:0] ST_HLT = 2'd1;
    localparam logic [1:0] ST_ADR = 2'd2;
    localparam logic [1:0] ST_INS = 2'd3;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_CHAR = 2'd1;
    localparam logic [1:0] PK_WORD = 2'd2;

    localparam logic [7:0] OP_NOP = 8'h00, OP_HALT = 8'h10, OP_RRMOV = 8'h20,
        OP_IRMOV = 8'h30, OP_RMMOV = 8'h40, OP_MRMOV = 8'h50, OP_ADD = 8'h60,
        OP_SUB = 8'h61, OP_AND = 8'h62, OP_XOR = 8'h63, OP_MUL = 8'h64,
        OP_CMP = 8'h65, OP_JMP = 8'h70, OP_JLE = 8'h71, OP_JL = 8'h72,
        OP_JE = 8'h73, OP_JNE = 8'h74, OP_JGE = 8'h75, OP_JG = 8'h76,
        OP_CALL = 8'h80, OP_RET = 8'h90, OP_PUSH = 8'ha0, OP_POP = 8'hb0,
        OP_READB = 8'hc0, OP_READL = 8'hc1, OP_WRITEB = 8'hd0, OP_WRITEL = 8'hd1,
        OP_MOVSB = 8'he0;

    localparam int REG_MEM_SIZE = 0;
    localparam int REG_START = 1;
    localparam logic [2:0] SP_REG = 3'd4;

    function automatic logic [2:0] instr_len(input logic [7:0] op);
        case (op)
            OP_NOP, OP_HALT, OP_RET: instr_len = 3'd1;
            OP_RRMOV, OP_ADD, OP_SUB, OP_AND, OP_XOR, OP_MUL, OP_CMP, OP_PUSH,
            OP_POP: instr_len = 3'd2;
            OP_JMP, OP_JLE, OP_JL, OP_JE, OP_JNE, OP_JGE, OP_JG, OP_CALL:
                instr_len = 3'd5;
            OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_READB, OP_READL, OP_WRITEB,
            OP_WRITEL, OP_MOVSB: instr_len = 3'd6;
            default: instr_len = 3'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

@@ hdl/y86_mem.sv @@
// byte memory of the y86 executor, one port, registered read
// depends on y86_pkg
`timescale 1ns / 1ps
`default_nettype none
module y86_mem #(
    parameter int MEM_BYTES = y86_pkg::MEM_BYTES_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire [$clog2(MEM_BYTES)-1:0] i_addr,
    input  wire [7:0]                   i_wdata,
    output logic [7:0]                  o_rdata
);
    logic [7:0] mem [MEM_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule
`default_nettype wire

@@ hdl/y86_instruction_executor_unit.sv @@
// y86 executor top level: sequencer, register file, flags
// depends on y86_pkg, y86_mem and the assertion header
// host byte access passes the host and done states; execute passes fetch, decode, execute,
// memory if needed and writeback, one byte per cycle through the single memory port (fetch, data)
// one item at a time: busy is high from start until the result strobe
// synchronous active-low reset: registers zero, sp mem_size-1, pc zero, status running
// the receiver cannot stall; each result is shown for one cycle
`timescale 1ns / 1ps
`default_nettype none
`include "y86_instruction_executor_unit_assert.svh"
module y86_instruction_executor_unit #(
    parameter int MEM_BYTES = y86_pkg::MEM_BYTES_DEF,
    parameter int NUM_REGS  = y86_pkg::NUM_REGS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire y86_pkg::t_in i_item,
    output logic              o_valid,
    output y86_pkg::t_out     o_result,
    input  wire               i_cfg_we,
    input  wire [0:0]         i_cfg_index,
    input  wire [12:0]        i_cfg_data
);
    import y86_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int RW = $clog2(NUM_REGS);

    localparam logic [3:0] S_IDLE = 4'd0, S_HOST = 4'd1, S_FETCH = 4'd2,
        S_DEC = 4'd3, S_EXE = 4'd4, S_MEM = 4'd5, S_WB = 4'd6, S_DONE = 4'd7;

    logic [3:0]  r_state, n_state;
    t_in         r_in;
    logic [31:0] r_regs [NUM_REGS];
    logic [11:0] r_pc;
    logic        r_zf, r_sf, r_of;
    logic [1:0]  r_st;
    logic [12:0] r_msize;
    logic [7:0]  r_ib [6];
    logic [2:0]  r_cnt;
    logic [2:0]  r_len;
    logic [31:0] r_addr;
    logic [31:0] r_data;
    logic        r_mwr;
    logic [2:0]  r_nb;
    logic        r_fetch_rd;
    logic [7:0]  r_rbyte;
    logic [1:0]  r_pk;
    logic        r_taken;
    logic [31:0] r_nx;

    // effective size
    logic [16:0] eff;
    assign eff = (17'(r_msize) > 17'(MEM_BYTES)) ? 17'(MEM_BYTES) : 17'(r_msize);

    function automatic logic fits(input logic [31:0] a, input logic [16:0] s,
                                  input logic [2:0] n);
        fits = (s >= 17'(n)) && ({1'b0, a} <= 33'(s) - 33'(n));
    endfunction

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_a;
    logic [7:0]    mem_wd, mem_rd;
    y86_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_a), .i_wdata(mem_wd), .o_rdata(mem_rd)
    );

    logic [31:0] fa;
    always_comb begin
        mem_we = 1'b0;
        mem_wd = r_in.write_byte;
        fa = 32'(r_pc) + 32'(r_cnt);
        mem_a = AW'(r_in.address);
        case (r_state)
            S_IDLE: begin
                mem_a = AW'(i_item.address);
                mem_we = start && (i_item.action == ACT_WR) &&
                         (17'(i_item.address) < eff);
                mem_wd = i_item.write_byte;
            end
            S_FETCH: mem_a = AW'(fa);
            S_MEM: begin
                fa = r_addr + 32'(r_cnt);
                mem_a = AW'(fa);
                mem_we = r_mwr;
                mem_wd = r_data[8*r_cnt[1:0] +: 8];
            end
            default: ;
        endcase
    end

    // decoded fields
    logic [7:0]  op;
    logic [3:0]  ra, rb;
    logic [31:0] disp;
    logic        need_a, need_b;
    always_comb begin
        op = r_ib[0];
        ra = (r_len >= 3'd2 && r_len != 3'd5) ? r_ib[1][7:4] : 4'd0;
        rb = (r_len >= 3'd2 && r_len != 3'd5) ? r_ib[1][3:0] : 4'd0;
        disp = (r_len == 3'd6) ? {r_ib[5], r_ib[4], r_ib[3], r_ib[2]} :
               (r_len == 3'd5) ? {r_ib[4], r_ib[3], r_ib[2], r_ib[1]} : 32'd0;
        case (op)
            OP_RRMOV, OP_RMMOV, OP_MRMOV, OP_ADD, OP_SUB, OP_AND, OP_XOR, OP_MUL,
            OP_CMP, OP_MOVSB: begin need_a = 1'b1; need_b = 1'b1; end
            OP_IRMOV: begin need_a = 1'b0; need_b = 1'b1; end
            OP_PUSH, OP_POP, OP_READB, OP_READL, OP_WRITEB, OP_WRITEL:
                begin need_a = 1'b1; need_b = 1'b0; end
            default: begin need_a = 1'b0; need_b = 1'b0; end
        endcase
    end

    logic [31:0] va, vb, sp;
    assign va = need_a ? r_regs[RW'(ra)] : 32'd0;
    assign vb = need_b ? r_regs[RW'(rb)] : 32'd0;
    assign sp = r_regs[SP_REG];

    logic signed [63:0] prod;
    assign prod = $signed(va) * $signed(vb);

    logic sov;
    assign sov = r_sf ^ r_of;

    logic [31:0] sum, dif;
    assign sum = vb + va;
    assign dif = vb - va;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = (i_item.action == ACT_EX && r_st == ST_AOK) ?
                                         S_FETCH : S_HOST;
            S_HOST: n_state = S_DONE;
            S_FETCH: n_state = S_FETCH;
            S_DEC: n_state = S_EXE;
            S_EXE: n_state = S_EXE;
            S_MEM: n_state = S_MEM;
            S_WB: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_msize <= 13'd4096;
            r_pc <= 12'd0;
            r_st <= ST_AOK;
            r_zf <= 1'b0; r_sf <= 1'b0; r_of <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= 32'd0;
            r_regs[SP_REG] <= 32'd4095;
            r_fetch_rd <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(REG_MEM_SIZE)) begin
                    r_msize <= i_cfg_data;
                    r_regs[SP_REG] <= 32'(i_cfg_data) - 32'd1;
                end else begin
                    r_pc <= i_cfg_data[11:0];
                end
            end
            case (r_state)
                S_IDLE: if (start) begin
                    r_in <= i_item;
                    r_cnt <= 3'd0;
                    r_rbyte <= 8'd0;
                    r_pk <= PK_NONE;
                    r_data <= 32'd0;
                    r_taken <= 1'b0;
                    r_fetch_rd <= 1'b0;
                    if (i_item.action == ACT_EX && r_st == ST_AOK &&
                        !fits(32'(r_pc), eff, 3'd1)) begin
                        r_st <= ST_ADR;
                        r_state <= S_HOST;
                    end
                end
                S_HOST: if (r_in.action == ACT_RD && 17'(r_in.address) < eff)
                    r_rbyte <= mem_rd;
                S_FETCH: begin
                    // read data shows up in the cycle after its address
                    r_fetch_rd <= 1'b1;
                    if (r_fetch_rd) begin
                        r_ib[r_cnt - 3'd1] <= mem_rd;
                        if (r_cnt == 3'd1) begin
                            r_len <= instr_len(mem_rd);
                            if (instr_len(mem_rd) == 3'd0) begin
                                r_st <= ST_INS; r_state <= S_DONE;
                            end else if (!fits(32'(r_pc), eff, instr_len(mem_rd))) begin
                                r_st <= ST_ADR; r_state <= S_DONE;
                            end else if (instr_len(mem_rd) == 3'd1) begin
                                r_state <= S_DEC;
                            end
                        end else if (r_cnt == r_len) begin
                            r_state <= S_DEC;
                        end
                    end
                    r_cnt <= r_cnt + 3'd1;
                end
                S_DEC: begin
                    r_nx <= 32'(r_pc) + 32'(r_len);
                    r_cnt <= 3'd0;
                    if ((need_a && ra >= 4'(NUM_REGS)) || (need_b && rb >= 4'(NUM_REGS))) begin
                        r_st <= ST_ADR; r_state <= S_DONE;
                    end
                end
                S_EXE: begin
                    r_state <= S_WB;
                    r_mwr <= 1'b0;
                    r_nb <= 3'd4;
                    case (op)
                        OP_RMMOV, OP_MRMOV: begin
                            r_addr <= disp + vb; r_data <= va; r_mwr <= (op == OP_RMMOV);
                            r_state <= fits(disp + vb, eff, 3'd4) ? S_MEM : S_DONE;
                            if (!fits(disp + vb, eff, 3'd4)) r_st <= ST_ADR;
                        end
                        OP_CALL, OP_PUSH: begin
                            r_addr <= sp - 32'd4; r_mwr <= 1'b1;
                            r_data <= (op == OP_CALL) ? r_nx : va;
                            r_state <= fits(sp - 32'd4, eff, 3'd4) ? S_MEM : S_DONE;
                            if (!fits(sp - 32'd4, eff, 3'd4)) r_st <= ST_ADR;
                        end
                        OP_RET, OP_POP: begin
                            r_addr <= sp;
                            r_state <= fits(sp, eff, 3'd4) ? S_MEM : S_DONE;
                            if (!fits(sp, eff, 3'd4)) r_st <= ST_ADR;
                        end
                        OP_READB, OP_WRITEB, OP_MOVSB: begin
                            r_addr <= disp + ((op == OP_MOVSB) ? vb : va);
                            r_nb <= 3'd1;
                            r_mwr <= (op == OP_READB);
                            r_data <= 32'(r_in.console_value[7:0]);
                            if (fits(disp + ((op == OP_MOVSB) ? vb : va), eff, 3'd1))
                                r_state <= S_MEM;
                            else begin
                                r_st <= ST_ADR; r_state <= S_DONE;
                            end
                        end
                        OP_READL, OP_WRITEL: begin
                            r_addr <= disp + va;
                            r_mwr <= (op == OP_READL);
                            r_data <= r_in.console_value;
                            if (!fits(disp + va, eff, 3'd4)) begin
                                r_st <= ST_ADR; r_state <= S_DONE;
                            end else if (op == OP_READL && r_in.console_eof) begin
                                r_zf <= 1'b1; r_st <= ST_HLT; r_pc <= r_nx[11:0];
                                r_state <= S_DONE;
                            end else r_state <= S_MEM;
                        end
                        default: ;
                    endcase
                end
                S_MEM: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (!r_mwr && r_cnt != 3'd0)
                        r_data[8*(r_cnt[1:0]-2'd1) +: 8] <= mem_rd;
                    if (r_mwr ? (r_cnt == r_nb - 3'd1) : (r_cnt == r_nb))
                        r_state <= S_WB;
                end
                S_WB: begin
                    r_pc <= r_nx[11:0];
                    case (op)
                        OP_HALT: r_st <= ST_HLT;
                        OP_RRMOV: r_regs[RW'(rb)] <= va;
                        OP_IRMOV: r_regs[RW'(rb)] <= disp;
                        OP_MRMOV: r_regs[RW'(ra)] <= r_data;
                        OP_ADD: begin
                            r_regs[RW'(rb)] <= sum; r_zf <= (sum == 32'd0);
                            r_sf <= sum[31]; r_of <= ~(va[31] ^ vb[31]) & (va[31] ^ sum[31]);
                        end
                        OP_SUB, OP_CMP: begin
                            if (op == OP_SUB) r_regs[RW'(rb)] <= dif;
                            r_zf <= (dif == 32'd0); r_sf <= dif[31];
                            r_of <= (vb[31] ^ va[31]) & (vb[31] ^ dif[31]);
                        end
                        OP_AND, OP_XOR: begin
                            r_regs[RW'(rb)] <= (op == OP_AND) ? (vb & va) : (vb ^ va);
                            r_zf <= (((op == OP_AND) ? (vb & va) : (vb ^ va)) == 32'd0);
                            r_sf <= (op == OP_AND) ? (vb[31] & va[31]) : (vb[31] ^ va[31]);
                            r_of <= 1'b0;
                        end
                        OP_MUL: begin
                            r_regs[RW'(rb)] <= prod[31:0]; r_zf <= (prod[31:0] == 32'd0);
                            r_sf <= prod[31];
                            r_of <= (prod[63:31] != {33{prod[31]}});
                        end
                        OP_CALL: begin
                            r_regs[SP_REG] <= sp - 32'd4; r_pc <= disp[11:0];
                        end
                        OP_PUSH: r_regs[SP_REG] <= sp - 32'd4;
                        OP_RET: begin
                            r_regs[SP_REG] <= sp + 32'd4; r_pc <= r_data[11:0];
                        end
                        OP_POP: begin
                            r_regs[SP_REG] <= sp + 32'd4; r_regs[RW'(ra)] <= r_data;
                        end
                        OP_READB: begin r_zf <= 1'b0; r_taken <= 1'b1; end
                        OP_READL: begin
                            r_taken <= 1'b1; r_zf <= r_data[31];
                            if (r_data[31]) r_st <= ST_HLT;
                        end
                        OP_WRITEB: r_pk <= PK_CHAR;
                        OP_WRITEL: r_pk <= PK_WORD;
                        OP_MOVSB: r_regs[RW'(ra)] <= {{24{r_data[7]}}, r_data[7:0]};
                        OP_JMP: r_pc <= disp[11:0];
                        OP_JLE: if (sov || r_zf) r_pc <= disp[11:0];
                        OP_JL:  if (sov) r_pc <= disp[11:0];
                        OP_JE:  if (r_zf) r_pc <= disp[11:0];
                        OP_JNE: if (!r_zf) r_pc <= disp[11:0];
                        OP_JGE: if (!sov) r_pc <= disp[11:0];
                        OP_JG:  if (!sov && !r_zf) r_pc <= disp[11:0];
                        default: ;
                    endcase
                end
                S_DONE: o_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_result.status = r_st;
        o_result.program_counter = r_pc;
        o_result.read_byte = r_rbyte;
        o_result.print_kind = r_pk;
        o_result.print_value = (r_pk == PK_CHAR) ? 32'(r_data[7:0]) :
                               (r_pk == PK_WORD) ? r_data : 32'd0;
        o_result.console_taken = r_taken;
    end

    `Y86_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `Y86_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, r_state == S_IDLE)
    `Y86_ASSERT_IMP(a_pk_zero, i_clk, i_rst_n, o_valid && r_in.action != ACT_EX,
                    o_result.print_kind == PK_NONE && !o_result.console_taken)
    `Y86_ASSERT_NXT(a_done_strobe, i_clk, i_rst_n, r_state == S_DONE, o_valid)
endmodule
`default_nettype wire
